// ===== hdl/cdsd_pkg.sv =====
// Shared constants and types of the shadow-buffered character display block.
`default_nettype none

package cdsd_pkg;

    localparam int COLUMNS_DEF   = 16;
    localparam int CELLS_DEF     = 32;
    localparam int LED_COUNT_DEF = 3;

    localparam logic [7:0] BLANK_RESET = 8'd32;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic REG_BLANK = 1'b0;

    localparam logic KIND_CELL = 1'b0;
    localparam logic KIND_LED  = 1'b1;

    typedef enum logic [1:0] {
        ACT_PLACE       = 2'd0,
        ACT_SET_LED     = 2'd1,
        ACT_FLUSH_CELLS = 2'd2,
        ACT_FLUSH_LEDS  = 2'd3
    } action_t;

endpackage

`default_nettype wire

// ===== hdl/cdsd_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
`default_nettype none

interface cdsd_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [3:0] column;
    logic       row;
    logic [7:0] code;
    logic [1:0] led_index;

    modport source (output valid, action, column, row, code, led_index, input ready);
    modport sink (input valid, action, column, row, code, led_index, output ready);
endinterface

interface cdsd_result_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [4:0] position;
    logic [7:0] cell_code;
    logic [2:0] led_pins;
    logic       last;

    modport source (output valid, kind, position, cell_code, led_pins, last, input ready);
    modport sink (input valid, kind, position, cell_code, led_pins, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/cdsd_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module cdsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/char_display_shadow_diff_update.sv =====
// Top level of the shadow-buffered character display with status LEDs.
//
// Place and set-LED items give no result. An LED flush loads its single result into
// the output register when it is taken. A display flush walks the cells one per
// cycle while the output register is free or being emptied, since both frames sit in
// RAMs with one read port each; every cycle in which the output register is full and
// not taken stalls the walk. The block takes a new item only when no flush is in
// progress and the output register is free or being emptied. After reset no clearing
// pass is needed; per-cell valid bits make unwritten cells read as the reset blank
// code.
`default_nettype none

module char_display_shadow_diff_update #(
    parameter int COLUMNS   = cdsd_pkg::COLUMNS_DEF,
    parameter int CELLS     = cdsd_pkg::CELLS_DEF,
    parameter int LED_COUNT = cdsd_pkg::LED_COUNT_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    cdsd_item_if.sink                        items,
    cdsd_result_if.source                    results,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [cdsd_pkg::APB_AW-1:0] paddr,
    input  wire logic [cdsd_pkg::APB_DW-1:0] pwdata,
    output logic      [cdsd_pkg::APB_DW-1:0] prdata,
    output logic                             pready
);

    localparam int AW = $clog2(CELLS);
    localparam int IW = $clog2(COLUMNS + 16 + CELLS);
    localparam logic [AW-1:0] LAST_IDX = AW'(CELLS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        cnt_reg, cnt_next;
    logic                 hold_vld_reg, hold_vld_next;
    logic [4:0]           hold_pos_reg, hold_pos_next;
    logic [7:0]           hold_code_reg, hold_code_next;
    logic                 out_vld_reg, out_vld_next;
    logic                 out_kind_reg, out_kind_next;
    logic [4:0]           out_pos_reg, out_pos_next;
    logic [7:0]           out_code_reg, out_code_next;
    logic [2:0]           out_pins_reg, out_pins_next;
    logic                 out_last_reg, out_last_next;
    logic [CELLS-1:0]     shown_vld_reg, shown_vld_next;
    logic [CELLS-1:0]     next_vld_reg, next_vld_next;
    logic [LED_COUNT-1:0] shown_leds_reg, shown_leds_next;
    logic [LED_COUNT-1:0] next_leds_reg, next_leds_next;
    logic [LED_COUNT-1:0] pins_reg, pins_next;
    logic [7:0]           blank_reg, blank_next;

    logic          out_free;
    logic          accept;
    logic          advance;
    logic [IW-1:0] place_idx;
    logic          place_ok;
    logic          place_we;
    logic [AW-1:0] rd_addr;
    logic [7:0]    shown_rdata;
    logic [7:0]    next_rdata;
    logic [7:0]    shown_val;
    logic [7:0]    next_val;
    logic          differ;
    logic          next_we;
    logic [AW-1:0] next_waddr;
    logic [7:0]    next_wdata;
    logic          cfg_write;

    assign out_free = !out_vld_reg || results.ready;
    assign items.ready = (state_reg == ST_IDLE) && out_free;
    assign accept = items.valid && items.ready;
    assign advance = (state_reg == ST_SCAN) && out_free;

    assign place_idx = IW'(items.row) * IW'(COLUMNS) + IW'(items.column);
    assign place_ok = place_idx < IW'(CELLS);
    assign place_we = accept && (cdsd_pkg::action_t'(items.action) == cdsd_pkg::ACT_PLACE)
                      && place_ok;

    always_comb
    begin
        if (state_reg == ST_SCAN)
        begin
            if (advance)
            begin
                rd_addr = (cnt_reg == LAST_IDX) ? '0 : cnt_reg + AW'(1);
            end
            else
            begin
                rd_addr = cnt_reg;
            end
        end
        else
        begin
            rd_addr = '0;
        end
    end

    assign shown_val = shown_vld_reg[cnt_reg] ? shown_rdata : cdsd_pkg::BLANK_RESET;
    assign next_val = next_vld_reg[cnt_reg] ? next_rdata : cdsd_pkg::BLANK_RESET;
    assign differ = shown_val != next_val;

    assign next_we = place_we || advance;
    assign next_waddr = advance ? cnt_reg : place_idx[AW-1:0];
    assign next_wdata = advance ? blank_reg : items.code;

    cdsd_ram #(
        .WIDTH(8),
        .DEPTH(CELLS)
    ) u_shown_ram (
        .clk  (clk),
        .we   (advance),
        .waddr(cnt_reg),
        .wdata(next_val),
        .raddr(rd_addr),
        .rdata(shown_rdata)
    );

    cdsd_ram #(
        .WIDTH(8),
        .DEPTH(CELLS)
    ) u_next_ram (
        .clk  (clk),
        .we   (next_we),
        .waddr(next_waddr),
        .wdata(next_wdata),
        .raddr(rd_addr),
        .rdata(next_rdata)
    );

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == cdsd_pkg::REG_BLANK) ? cdsd_pkg::APB_DW'(blank_reg) : '0;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        hold_vld_next   = hold_vld_reg;
        hold_pos_next   = hold_pos_reg;
        hold_code_next  = hold_code_reg;
        out_vld_next    = out_vld_reg && !results.ready;
        out_kind_next   = out_kind_reg;
        out_pos_next    = out_pos_reg;
        out_code_next   = out_code_reg;
        out_pins_next   = out_pins_reg;
        out_last_next   = out_last_reg;
        shown_vld_next  = shown_vld_reg;
        next_vld_next   = next_vld_reg;
        shown_leds_next = shown_leds_reg;
        next_leds_next  = next_leds_reg;
        pins_next       = pins_reg;
        blank_next      = blank_reg;

        if (cfg_write && (paddr[2] == cdsd_pkg::REG_BLANK))
        begin
            blank_next = pwdata[7:0];
        end

        if (place_we)
        begin
            next_vld_next[place_idx[AW-1:0]] = 1'b1;
        end

        if (accept)
        begin
            case (cdsd_pkg::action_t'(items.action))
                cdsd_pkg::ACT_SET_LED:
                begin
                    for (int i = 0; i < LED_COUNT; i++)
                    begin
                        if (int'(items.led_index) == i)
                        begin
                            next_leds_next[i] = 1'b1;
                        end
                    end
                end
                cdsd_pkg::ACT_FLUSH_CELLS:
                begin
                    state_next    = ST_SCAN;
                    cnt_next      = '0;
                    hold_vld_next = 1'b0;
                end
                cdsd_pkg::ACT_FLUSH_LEDS:
                begin
                    pins_next       = pins_reg ^ (next_leds_reg ^ shown_leds_reg);
                    shown_leds_next = next_leds_reg;
                    next_leds_next  = '0;
                    out_vld_next    = 1'b1;
                    out_kind_next   = cdsd_pkg::KIND_LED;
                    out_pos_next    = '0;
                    out_code_next   = '0;
                    out_pins_next   = 3'(pins_reg ^ (next_leds_reg ^ shown_leds_reg));
                    out_last_next   = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            ST_SCAN:
            begin
                if (advance)
                begin
                    shown_vld_next[cnt_reg] = 1'b1;
                    next_vld_next[cnt_reg]  = 1'b1;
                    if (differ)
                    begin
                        if (hold_vld_reg)
                        begin
                            out_vld_next  = 1'b1;
                            out_kind_next = cdsd_pkg::KIND_CELL;
                            out_pos_next  = hold_pos_reg;
                            out_code_next = hold_code_reg;
                            out_pins_next = '0;
                            out_last_next = 1'b0;
                        end
                        hold_vld_next  = 1'b1;
                        hold_pos_next  = 5'(cnt_reg);
                        hold_code_next = next_val;
                    end
                    if (cnt_reg == LAST_IDX)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + AW'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    if (hold_vld_reg)
                    begin
                        out_vld_next  = 1'b1;
                        out_kind_next = cdsd_pkg::KIND_CELL;
                        out_pos_next  = hold_pos_reg;
                        out_code_next = hold_code_reg;
                        out_pins_next = '0;
                        out_last_next = 1'b1;
                    end
                    hold_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            hold_vld_reg   <= 1'b0;
            hold_pos_reg   <= '0;
            hold_code_reg  <= '0;
            out_vld_reg    <= 1'b0;
            out_kind_reg   <= 1'b0;
            out_pos_reg    <= '0;
            out_code_reg   <= '0;
            out_pins_reg   <= '0;
            out_last_reg   <= 1'b0;
            shown_vld_reg  <= '0;
            next_vld_reg   <= '0;
            shown_leds_reg <= '0;
            next_leds_reg  <= '0;
            pins_reg       <= '0;
            blank_reg      <= cdsd_pkg::BLANK_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            hold_vld_reg   <= hold_vld_next;
            hold_pos_reg   <= hold_pos_next;
            hold_code_reg  <= hold_code_next;
            out_vld_reg    <= out_vld_next;
            out_kind_reg   <= out_kind_next;
            out_pos_reg    <= out_pos_next;
            out_code_reg   <= out_code_next;
            out_pins_reg   <= out_pins_next;
            out_last_reg   <= out_last_next;
            shown_vld_reg  <= shown_vld_next;
            next_vld_reg   <= next_vld_next;
            shown_leds_reg <= shown_leds_next;
            next_leds_reg  <= next_leds_next;
            pins_reg       <= pins_next;
            blank_reg      <= blank_next;
        end
    end

    assign results.valid     = out_vld_reg;
    assign results.kind      = out_kind_reg;
    assign results.position  = out_pos_reg;
    assign results.cell_code = out_code_reg;
    assign results.led_pins  = out_pins_reg;
    assign results.last      = out_last_reg;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the character display with shadow frame and status LEDs.

module tb_top;
    import cdsd_pkg::*;

    localparam int COLUMNS      = COLUMNS_DEF;
    localparam int CELLS        = CELLS_DEF;
    localparam int LED_COUNT    = LED_COUNT_DEF;
    localparam int SETTLE       = CELLS + 8;
    localparam int LONG_HOLD    = 300;
    localparam int QUIET_LIMIT  = 2000;

    typedef struct {
        action_t    action;
        logic [3:0] column;
        logic       row;
        logic [7:0] code;
        logic [1:0] led_index;
        bit         wait_drain;
    } display_item_t;

    typedef struct packed {
        logic       kind;
        logic [4:0] position;
        logic [7:0] cell_code;
        logic [2:0] led_pins;
        logic       last;
    } display_update_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    cdsd_item_if   items_ch();
    cdsd_result_if results_ch();

    char_display_shadow_diff_update DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    display_item_t   item_backlog[$];
    display_update_t expected_updates[$];
    display_item_t   next_item;
    display_update_t got_update;
    display_update_t want_update;

    logic [7:0]           shown_frame[CELLS];
    logic [7:0]           next_frame[CELLS];
    logic [LED_COUNT-1:0] shown_leds;
    logic [LED_COUNT-1:0] next_leds;
    logic [LED_COUNT-1:0] pin_state;
    logic [7:0]           blank_char;

    int mismatch_count = 0;
    int send_gap;
    int hold_left;
    int stall_requests = 0;
    int stalls_served;
    int quiet_cycles = 0;
    bit sender_idles = 1'b0;
    bit receiver_idles = 1'b0;
    bit drain_next = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic int pick_code();
        case ($urandom_range(0, 9))
            5: return 0;
            6: return 255;
            7: return 32;
            8: return blank_char;
            9: return $urandom_range(30, 34);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic add_item(input action_t act, input int col, input int row, input int ch,
                            input int led);
        display_item_t it;
        it.action = act;
        it.column = 4'(col);
        it.row = 1'(row);
        it.code = 8'(ch);
        it.led_index = 2'(led);
        it.wait_drain = drain_next;
        drain_next = 1'b0;
        item_backlog.push_back(it);
    endtask

    task automatic add_flush(input action_t act);
        add_item(act, $urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 255),
                 $urandom_range(0, 3));
    endtask

    task automatic add_full_frame();
        int order[CELLS];
        int j;
        int t;
        for (int i = 0; i < CELLS; i++)
            order[i] = i;
        for (int i = CELLS - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < CELLS; i++)
            add_item(ACT_PLACE, order[i] % COLUMNS, order[i] / COLUMNS, pick_code(),
                     $urandom_range(0, 3));
        add_flush(ACT_FLUSH_CELLS);
    endtask

    task automatic add_random_items(input int count);
        int start;
        int sel;
        int n;
        start = item_backlog.size();
        while (item_backlog.size() - start < count)
        begin
            sel = $urandom_range(0, 99);
            if ($urandom_range(0, 29) == 0)
                drain_next = 1'b1;
            if (sel < 10)
                add_full_frame();
            else if (sel < 62)
            begin
                n = $urandom_range(0, 8);
                for (int k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 5) == 0)
                        add_item(ACT_SET_LED, $urandom_range(0, 15), $urandom_range(0, 1),
                                 $urandom_range(0, 255), $urandom_range(0, 3));
                    else
                        add_item(ACT_PLACE, $urandom_range(0, 15), $urandom_range(0, 1),
                                 pick_code(), $urandom_range(0, 3));
                end
                add_flush(ACT_FLUSH_CELLS);
            end
            else if (sel < 85)
            begin
                n = $urandom_range(0, 4);
                for (int k = 0; k < n; k++)
                    add_item(ACT_SET_LED, $urandom_range(0, 15), $urandom_range(0, 1),
                             $urandom_range(0, 255), $urandom_range(0, 3));
                add_flush(ACT_FLUSH_LEDS);
            end
            else
            begin
                n = $urandom_range(1, 5);
                for (int k = 0; k < n; k++)
                    add_item(action_t'($urandom_range(0, 3)), $urandom_range(0, 15),
                             $urandom_range(0, 1), pick_code(), $urandom_range(0, 3));
            end
        end
    endtask

    // Updates the frame and LED model for one transfer and queues the resulting updates.
    task automatic predict_display_item(input action_t act, input logic [3:0] col,
                                        input logic row, input logic [7:0] ch,
                                        input logic [1:0] led);
        int pos;
        int emitted;
        display_update_t upd;
        case (act)
            ACT_PLACE:
            begin
                pos = int'(row) * COLUMNS + int'(col);
                if (pos < CELLS)
                    next_frame[pos] = ch;
            end
            ACT_SET_LED:
            begin
                if (int'(led) < LED_COUNT)
                    next_leds[led] = 1'b1;
            end
            ACT_FLUSH_CELLS:
            begin
                emitted = 0;
                for (int i = 0; i < CELLS; i++)
                begin
                    if (shown_frame[i] != next_frame[i])
                    begin
                        upd.kind = KIND_CELL;
                        upd.position = 5'(i);
                        upd.cell_code = next_frame[i];
                        upd.led_pins = '0;
                        upd.last = 1'b0;
                        expected_updates.push_back(upd);
                        emitted++;
                    end
                    shown_frame[i] = next_frame[i];
                    next_frame[i] = blank_char;
                end
                if (emitted > 0)
                    expected_updates[expected_updates.size() - 1].last = 1'b1;
            end
            ACT_FLUSH_LEDS:
            begin
                pin_state ^= next_leds ^ shown_leds;
                shown_leds = next_leds;
                next_leds = '0;
                upd.kind = KIND_LED;
                upd.position = '0;
                upd.cell_code = '0;
                upd.led_pins = 3'(pin_state);
                upd.last = 1'b1;
                expected_updates.push_back(upd);
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic write_blank_code(input logic [7:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'(4 * REG_BLANK);
        pwdata <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        blank_char = value;
    endtask

    task automatic wait_until_idle();
        do
            @(posedge clk);
        while (item_backlog.size() != 0 || items_ch.valid || expected_updates.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            items_ch.valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (items_ch.valid && items_ch.ready)
                predict_display_item(action_t'(items_ch.action), items_ch.column, items_ch.row,
                                     items_ch.code, items_ch.led_index);
            if (!items_ch.valid || items_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    items_ch.valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (item_backlog.size() != 0 &&
                         !(item_backlog[0].wait_drain && expected_updates.size() != 0))
                begin
                    next_item = item_backlog.pop_front();
                    items_ch.valid <= 1'b1;
                    items_ch.action <= next_item.action;
                    items_ch.column <= next_item.column;
                    items_ch.row <= next_item.row;
                    items_ch.code <= next_item.code;
                    items_ch.led_index <= next_item.led_index;
                    send_gap <= sender_idles ? idle_length() : 0;
                end
                else
                    items_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_ch.ready <= 1'b0;
            hold_left <= 0;
            stalls_served <= 0;
        end
        else if (stalls_served != stall_requests)
        begin
            stalls_served <= stall_requests;
            hold_left <= LONG_HOLD - 1;
            results_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            results_ch.ready <= 1'b0;
        end
        else if (receiver_idles && $urandom_range(0, 3) == 0)
        begin
            hold_left <= idle_length();
            results_ch.ready <= 1'b0;
        end
        else
            results_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            got_update.kind = results_ch.kind;
            got_update.position = results_ch.position;
            got_update.cell_code = results_ch.cell_code;
            got_update.led_pins = results_ch.led_pins;
            got_update.last = results_ch.last;
            if (expected_updates.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, actual %p", $time, got_update);
                mismatch_count++;
            end
            else
            begin
                want_update = expected_updates.pop_front();
                check_field("kind", want_update.kind, got_update.kind);
                check_field("position", want_update.position, got_update.position);
                check_field("cell_code", want_update.cell_code, got_update.cell_code);
                check_field("led_pins", want_update.led_pins, got_update.led_pins);
                check_field("last", want_update.last, got_update.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || psel || (items_ch.valid && items_ch.ready) ||
            (results_ch.valid && results_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        items_ch.valid = 1'b0;
        items_ch.action = ACT_PLACE;
        items_ch.column = '0;
        items_ch.row = 1'b0;
        items_ch.code = '0;
        items_ch.led_index = '0;
        results_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        blank_char = BLANK_RESET;
        for (int i = 0; i < CELLS; i++)
        begin
            shown_frame[i] = BLANK_RESET;
            next_frame[i] = BLANK_RESET;
        end
        shown_leds = '0;
        next_leds = '0;
        pin_state = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        add_item(ACT_PLACE, 0, 0, 8'h00, 0);
        add_item(ACT_PLACE, 15, 1, 8'hFF, 3);
        add_item(ACT_PLACE, 15, 0, BLANK_RESET, 1);
        add_item(ACT_PLACE, 7, 1, 8'h41, 2);
        add_item(ACT_PLACE, 7, 1, 8'h5A, 0);
        add_item(ACT_PLACE, 3, 0, 8'h80, 3);
        add_item(ACT_PLACE, 12, 1, 8'h7F, 1);
        add_item(ACT_FLUSH_CELLS, 0, 0, 8'h00, 0);
        add_item(ACT_FLUSH_CELLS, 15, 1, 8'hFF, 3);
        add_item(ACT_FLUSH_CELLS, 5, 0, 8'h3C, 2);
        add_item(ACT_SET_LED, 0, 0, 8'h00, 0);
        add_item(ACT_SET_LED, 15, 1, 8'hFF, 2);
        add_item(ACT_SET_LED, 9, 0, 8'h11, 3);
        add_item(ACT_SET_LED, 2, 1, 8'h22, 2);
        add_item(ACT_FLUSH_LEDS, 0, 0, 8'h00, 0);
        add_item(ACT_FLUSH_LEDS, 15, 1, 8'hFF, 3);
        add_item(ACT_FLUSH_LEDS, 4, 1, 8'h99, 1);
        add_item(ACT_SET_LED, 6, 0, 8'h55, 1);
        add_item(ACT_FLUSH_LEDS, 8, 0, 8'hAA, 2);
        add_item(ACT_PLACE, 0, 0, BLANK_RESET, 2);
        add_item(ACT_PLACE, 10, 1, BLANK_RESET, 1);
        add_item(ACT_FLUSH_CELLS, 1, 1, 8'h01, 1);
        wait_until_idle();

        write_blank_code(8'h00);
        sender_idles <= 1'b1;
        receiver_idles <= 1'b1;
        add_random_items(120);
        wait_until_idle();

        // The output side is held off while full frames keep the input side busy.
        write_blank_code(8'hFF);
        sender_idles <= 1'b0;
        stall_requests <= stall_requests + 1;
        add_full_frame();
        add_full_frame();
        drain_next = 1'b1;
        add_full_frame();
        add_random_items(30);
        wait_until_idle();

        write_blank_code(8'($urandom_range(1, 254)));
        sender_idles <= 1'b1;
        receiver_idles <= 1'b1;
        add_random_items(70);
        wait_until_idle();

        write_blank_code(8'($urandom_range(1, 254)));
        sender_idles <= 1'b0;
        receiver_idles <= 1'b0;
        add_random_items(70);
        wait_until_idle();

        if (mismatch_count == 0 && expected_updates.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
